// File: hw/rtl/fobs_pkg.sv
// Shared types and constants for the first-occurrence byte search.
package fobs_pkg;

	localparam int PATTERN_MAX = 64;
	localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
	localparam int POS_W       = 32;

	typedef enum logic [1:0] {
		CMD_BEGIN  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_HAY    = 2'd2,
		CMD_END    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	typedef struct packed {
		logic       clear;
		logic       load;
		logic       shift;
		logic [7:0] data;
	} cell_ctl_t;

endpackage

// File: hw/rtl/fobs_if.sv
// Valid/ready stream interfaces for input items and results.
interface fobs_in_if import fobs_pkg::*; ();
	logic       valid;
	logic       ready;
	cmd_t       cmd;
	logic [7:0] data_byte;

	modport source (output valid, output cmd, output data_byte, input ready);
	modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface fobs_out_if import fobs_pkg::*; ();
	logic             valid;
	logic             ready;
	status_t          status;
	logic [POS_W-1:0] position;

	modport source (output valid, output status, output position, input ready);
	modport sink (input valid, input status, input position, output ready);
endinterface

// File: hw/rtl/fobs_cell.sv
// One pattern cell: a pattern byte, its loaded flag and its partial-match bit.
module fobs_cell import fobs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      prev_loaded,
	input  logic      prev_match,
	input  logic      next_loaded,
	output logic      loaded,
	output logic      match,
	output logic      hit
);

	logic [7:0] pat_q;
	logic       loaded_q;
	logic       match_q;
	logic       take;
	logic       match_d;

	assign take    = ctl.load & prev_loaded & ~loaded_q;
	assign match_d = prev_match & loaded_q & (pat_q == ctl.data);
	assign hit     = match_d & ~next_loaded;
	assign loaded  = loaded_q;
	assign match   = match_q;

	always_ff @(posedge clk) begin
		if (take) begin
			pat_q <= ctl.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= 1'b0;
			match_q  <= 1'b0;
		end else if (ctl.clear) begin
			loaded_q <= 1'b0;
			match_q  <= 1'b0;
		end else begin
			if (take) begin
				loaded_q <= 1'b1;
			end
			if (ctl.shift) begin
				match_q <= match_d;
			end
		end
	end

endmodule

// File: hw/rtl/fobs_chain.sv
// Row of pattern cells; reports a full match at the last loaded cell.
module fobs_chain import fobs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	output logic      hit,
	output logic      full
);

	logic [PATTERN_MAX-1:0] loaded;
	logic [PATTERN_MAX-1:0] match;
	logic [PATTERN_MAX-1:0] hits;

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		logic prev_loaded;
		logic prev_match;
		logic next_loaded;

		if (i == 0) begin : g_first
			assign prev_loaded = 1'b1;
			assign prev_match  = 1'b1;
		end else begin : g_rest
			assign prev_loaded = loaded[i-1];
			assign prev_match  = match[i-1];
		end

		if (i == PATTERN_MAX - 1) begin : g_last
			assign next_loaded = 1'b0;
		end else begin : g_mid
			assign next_loaded = loaded[i+1];
		end

		fobs_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.prev_loaded (prev_loaded),
			.prev_match  (prev_match),
			.next_loaded (next_loaded),
			.loaded      (loaded[i]),
			.match       (match[i]),
			.hit         (hits[i])
		);
	end

	assign hit  = |hits;
	assign full = loaded[PATTERN_MAX-1];

endmodule

// File: hw/rtl/first_occurrence_byte_search.sv
// Top level of the first-occurrence byte search: control, counters and result register.
//
//   channel  dir  payload                      transfer
//   item     in   cmd[1:0], data_byte[7:0]     item.valid & item.ready
//   result   out  status[1:0], position[31:0]  result.valid & result.ready
//
// One item per cycle while item.ready is high; every item is decided in the cycle it transfers and its result,
// if any, sits in the output register on the next cycle.
// The cell row updates all partial-match bits in parallel; no iteration.
// item.ready is low only while a result waits and result.ready is low.
// Reset clears the search as a begin item does and also drops a waiting result; pattern bytes are not cleared.
module first_occurrence_byte_search import fobs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	fobs_in_if.sink    item,
	fobs_out_if.source result
);

	logic [LEN_W-1:0] length_q;
	logic [POS_W-1:0] count_q;
	logic             reported_q;
	logic             overflow_q;

	logic             out_valid_q;
	status_t          status_q;
	logic [POS_W-1:0] position_q;

	logic             fire;
	logic             do_append;
	cell_ctl_t        ctl;
	logic             hit;
	logic             full;

	logic             emit;
	status_t          emit_status;
	logic [POS_W-1:0] emit_pos;
	logic [LEN_W-1:0] back;
	logic [POS_W-1:0] back_ext;

	assign item.ready = ~out_valid_q | result.ready;
	assign fire       = item.valid & item.ready;

	assign do_append = fire & (item.cmd == CMD_APPEND) & ~reported_q & (count_q == '0);

	assign ctl.clear = fire & (item.cmd == CMD_BEGIN);
	assign ctl.load  = do_append & ~full;
	assign ctl.shift = fire & (item.cmd == CMD_HAY) & ~reported_q & ~overflow_q
		& (length_q != '0);
	assign ctl.data  = item.data_byte;

	fobs_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.hit    (hit),
		.full   (full)
	);

	assign back     = length_q - LEN_W'(1);
	assign back_ext = POS_W'(back);

	always_comb begin
		emit        = 1'b0;
		emit_status = ST_FOUND;
		emit_pos    = '0;
		if (fire && !reported_q) begin
			unique case (item.cmd)
				CMD_HAY: begin
					if (!overflow_q) begin
						if (length_q == '0) begin
							emit = 1'b1;
						end else if (hit) begin
							emit     = 1'b1;
							emit_pos = (count_q >= back_ext) ? count_q - back_ext : '0;
						end
					end
				end
				CMD_END: begin
					emit = 1'b1;
					if (overflow_q) begin
						emit_status = ST_OVERFLOW;
					end else if (length_q != '0) begin
						emit_status = ST_NOT_FOUND;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q   <= '0;
			count_q    <= '0;
			reported_q <= 1'b0;
			overflow_q <= 1'b0;
		end else if (ctl.clear) begin
			length_q   <= '0;
			count_q    <= '0;
			reported_q <= 1'b0;
			overflow_q <= 1'b0;
		end else begin
			if (do_append) begin
				if (full) begin
					overflow_q <= 1'b1;
				end else begin
					length_q <= length_q + LEN_W'(1);
				end
			end
			if (fire && item.cmd == CMD_HAY && !reported_q && count_q != '1) begin
				count_q <= count_q + POS_W'(1);
			end
			if (emit) begin
				reported_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q   <= emit_status;
			position_q <= emit_pos;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.status   = status_q;
	assign result.position = position_q;

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !reported_q)
		else $error("second result in one search");

	a_reported: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !ctl.clear |=> reported_q)
		else $error("result not marked as reported");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		full == (length_q == LEN_W'(PATTERN_MAX)))
		else $error("cell row and pattern length disagree");

	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |-> full)
		else $error("overflow without full pattern");

endmodule

// File: test/first_occurrence_byte_search_tb.sv
// Self-checking testbench for the byte search: random streams against a shift-and predictor.
module first_occurrence_byte_search_tb import fobs_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 1300;
	localparam int CALM_FIRST = 400;
	localparam int CALM_LAST = 700;

	typedef struct {
		cmd_t       cmd;
		logic [7:0] data;
	} search_item_t;

	typedef struct {
		status_t     status;
		logic [31:0] position;
	} search_result_t;

	logic clk = 1'b0;
	logic arst_n;

	fobs_in_if  item_ch ();
	fobs_out_if result_ch ();

	first_occurrence_byte_search u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	search_item_t   pending_items[$];
	search_result_t awaited_results[$];
	int             mismatches = 0;
	int             sent_count = 0;
	int             cycles = 0;
	logic           took = 1'b0;

	// predictor state
	logic [7:0]             pat_bytes[PATTERN_MAX];
	int                     pat_len = 0;
	logic [PATTERN_MAX-1:0] hit_bits = '0;
	logic [31:0]            hay_count = '0;
	logic                   done = 1'b0;
	logic                   ovf = 1'b0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic post_result(input status_t st, input logic [31:0] pos);
		search_result_t r;
		r.status = st;
		r.position = pos;
		awaited_results.push_back(r);
		done = 1'b1;
	endtask

	task automatic search_step(input cmd_t c, input logic [7:0] b);
		logic [PATTERN_MAX-1:0] mask;
		logic [31:0]            here;
		logic [31:0]            back;
		case (c)
			CMD_BEGIN: begin
				pat_len = 0;
				hit_bits = '0;
				hay_count = '0;
				done = 1'b0;
				ovf = 1'b0;
			end
			CMD_APPEND: begin
				if (!done && hay_count == 0) begin
					if (pat_len < PATTERN_MAX) begin
						pat_bytes[pat_len] = b;
						pat_len++;
					end else begin
						ovf = 1'b1;
					end
				end
			end
			CMD_HAY: begin
				if (!done) begin
					here = hay_count;
					if (hay_count != 32'hFFFF_FFFF)
						hay_count++;
					if (!ovf) begin
						if (pat_len == 0) begin
							post_result(ST_FOUND, '0);
						end else begin
							mask = '0;
							for (int k = 0; k < pat_len; k++)
								mask[k] = (pat_bytes[k] == b);
							hit_bits = ((hit_bits << 1) | 1) & mask;
							if (hit_bits[pat_len-1]) begin
								back = pat_len - 1;
								post_result(ST_FOUND, (here >= back) ? here - back : '0);
							end
						end
					end
				end
			end
			CMD_END: begin
				if (!done) begin
					if (ovf)
						post_result(ST_OVERFLOW, '0);
					else if (pat_len == 0)
						post_result(ST_FOUND, '0);
					else
						post_result(ST_NOT_FOUND, '0);
				end
			end
		endcase
	endtask

	task automatic push_item(input cmd_t c, input logic [7:0] b);
		search_item_t it;
		it.cmd = c;
		it.data = b;
		pending_items.push_back(it);
	endtask

	// checks come before prediction so a result never meets an expectation of the same edge
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("unexpected result, status", 32'(result_ch.status), '0);
			end else begin
				search_result_t w;
				w = awaited_results.pop_front();
				if (result_ch.status != w.status)
					report_mismatch("status", 32'(result_ch.status), 32'(w.status));
				if (result_ch.position != w.position)
					report_mismatch("position", result_ch.position, w.position);
			end
		end
		if (arst_n && item_ch.valid && item_ch.ready) begin
			search_step(item_ch.cmd, item_ch.data_byte);
			sent_count <= sent_count + 1;
		end
		took <= arst_n && item_ch.valid && item_ch.ready;
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			result_ch.ready <= 1'b0;
		end else begin : drive
			logic         calm;
			search_item_t nxt;
			calm = sent_count >= CALM_FIRST && sent_count < CALM_LAST;
			if (!item_ch.valid || took) begin
				if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 33)) begin
					nxt = pending_items.pop_front();
					item_ch.valid <= 1'b1;
					item_ch.cmd <= nxt.cmd;
					item_ch.data_byte <= nxt.data;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
			result_ch.ready <= calm || $urandom_range(0, 99) >= 33;
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		logic [7:0] alpha[3];
		logic [7:0] pat[$];
		logic [7:0] b;
		int         sel;
		int         plen;
		int         hlen;
		int         at;
		logic       plant;
		int         target;

		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.cmd = CMD_BEGIN;
		item_ch.data_byte = '0;
		result_ch.ready = 1'b0;

		// empty pattern right after reset
		push_item(CMD_END, 8'h00);
		// empty pattern at first haystack byte, then everything ignored
		push_item(CMD_BEGIN, 8'hFF);
		push_item(CMD_HAY, 8'hFF);
		push_item(CMD_HAY, 8'h00);
		push_item(CMD_APPEND, 8'h00);
		push_item(CMD_END, 8'h00);
		// overlapping prefix, match at 1
		push_item(CMD_BEGIN, 8'h00);
		push_item(CMD_APPEND, 8'h00);
		push_item(CMD_APPEND, 8'hFF);
		push_item(CMD_HAY, 8'h00);
		push_item(CMD_HAY, 8'h00);
		push_item(CMD_HAY, 8'hFF);
		push_item(CMD_END, 8'hFF);
		// empty haystack
		push_item(CMD_BEGIN, 8'h00);
		push_item(CMD_APPEND, 8'hAA);
		push_item(CMD_END, 8'h00);
		// late pattern byte is dropped
		push_item(CMD_BEGIN, 8'h00);
		push_item(CMD_APPEND, 8'h55);
		push_item(CMD_HAY, 8'h12);
		push_item(CMD_APPEND, 8'h12);
		push_item(CMD_HAY, 8'h12);
		push_item(CMD_HAY, 8'h55);
		// single byte at position 0
		push_item(CMD_BEGIN, 8'h00);
		push_item(CMD_APPEND, 8'h7E);
		push_item(CMD_HAY, 8'h7E);

		target = pending_items.size() + RANDOM_ITEMS;
		while (pending_items.size() < target) begin
			if ($urandom_range(0, 19) == 0) begin
				push_item(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
				continue;
			end
			for (int k = 0; k < 3; k++)
				alpha[k] = 8'($urandom_range(0, 255));
			sel = $urandom_range(0, 99);
			if (sel < 5)
				plen = 0;
			else if (sel < 85)
				plen = $urandom_range(1, 5);
			else if (sel < 95)
				plen = $urandom_range(6, 20);
			else if (sel < 98)
				plen = $urandom_range(PATTERN_MAX - 4, PATTERN_MAX);
			else
				plen = $urandom_range(PATTERN_MAX + 1, PATTERN_MAX + 4);
			push_item(CMD_BEGIN, 8'($urandom_range(0, 255)));
			pat.delete();
			for (int k = 0; k < plen; k++) begin
				if ($urandom_range(0, 9) == 0)
					b = 8'($urandom_range(0, 255));
				else
					b = alpha[$urandom_range(0, 2)];
				pat.push_back(b);
				push_item(CMD_APPEND, b);
			end
			hlen = $urandom_range(0, plen + 24);
			plant = $urandom_range(0, 1) && hlen >= plen;
			at = plant ? $urandom_range(0, hlen - plen) : 0;
			for (int k = 0; k < hlen; k++) begin
				if (plant && k >= at && k < at + plen)
					b = pat[k-at];
				else
					b = alpha[$urandom_range(0, 2)];
				push_item(CMD_HAY, b);
				if ($urandom_range(0, 49) == 0)
					push_item($urandom_range(0, 3) == 0 ? CMD_BEGIN : CMD_APPEND,
						8'($urandom_range(0, 255)));
			end
			if ($urandom_range(0, 9) != 0)
				push_item(CMD_END, 8'($urandom_range(0, 255)));
			if ($urandom_range(0, 9) == 0)
				push_item($urandom_range(0, 1) ? CMD_HAY : CMD_END, 8'($urandom_range(0, 255)));
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || item_ch.valid || awaited_results.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		if (awaited_results.size() != 0)
			report_mismatch("results never seen", awaited_results.size(), '0);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
